// ===== rtl/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants for the modular square root block.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
    localparam int NQR_LIMIT = 1024;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef struct packed {
        t_word value;
        t_word prime;
    } t_in_item;

    typedef struct packed {
        t_word root;
        logic  status;
    } t_out_item;

    // Datapath commands issued by the controller
    typedef enum logic [5:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_RED,
        DP_SET_A,
        DP_POW_EULER,
        DP_POW_NQR,
        DP_POW_C,
        DP_POW_T,
        DP_POW_R,
        DP_MUL_ACC,
        DP_MUL_BASE,
        DP_SET_ACC,
        DP_SET_BASE,
        DP_Q_INIT,
        DP_Q_SHIFT,
        DP_Z_INIT,
        DP_Z_INC,
        DP_SET_C,
        DP_SET_T,
        DP_SET_R,
        DP_TT_INIT,
        DP_MUL_BB,
        DP_TT_STEP,
        DP_B_INIT,
        DP_B_STEP,
        DP_SET_CSQ,
        DP_MUL_RB,
        DP_SET_RB,
        DP_MUL_TC,
        DP_SET_TC,
        DP_MUL_RR,
        DP_RES_ZERO,
        DP_RES_FAIL,
        DP_RES_LSB,
        DP_RES_ROOT
    } t_dp_op;

    // Datapath flags returned to the controller
    typedef struct packed {
        logic p_zero;
        logic p_one;
        logic p_two;
        logic p_even;
        logic a_zero;
        logic e_zero;
        logic e_odd;
        logic acc_one;
        logic acc_pm1;
        logic q_even;
        logic z_ok;
        logic t_one;
        logic tt_one;
        logic ord_lt_m;
        logic k_loop;
        logic sq_match;
        logic mm_done;
    } t_dp_sts;

    typedef enum logic [5:0] {
        S_IDLE,
        S_CHK,
        S_RED_W,
        S_A_CHK,
        S_POW,
        S_POW_WA,
        S_POW_SQ,
        S_POW_WB,
        S_EULER_D,
        S_Q_LOOP,
        S_NQR,
        S_NQR_D,
        S_C_D,
        S_T_START,
        S_T_D,
        S_R_START,
        S_R_D,
        S_LOOP,
        S_ORD,
        S_ORD_W,
        S_BLOOP,
        S_B_W,
        S_CSQ_W,
        S_RB,
        S_RB_W,
        S_TC,
        S_TC_W,
        S_FIN_W,
        S_OUT
    } t_state;

endpackage

// ===== rtl/msr_mulmod.sv =====
// ----------------------------------------------------------------------------
// msr_mulmod
// Bit-serial modular multiplier: x * y mod m, one bit of y per cycle,
// most significant first. Requires x < m; y may take any value.
// ----------------------------------------------------------------------------
module msr_mulmod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  msr_pkg::t_word i_x,
    input  msr_pkg::t_word i_y,
    input  msr_pkg::t_word i_mod,
    output logic           o_done,
    output msr_pkg::t_word o_res
);
    import msr_pkg::*;

    logic  r_busy;
    logic  r_done;
    t_cnt  r_cnt;
    t_word r_acc;
    t_word r_x;
    t_word r_y;
    t_word n_acc;

    // (x + y) mod m for x, y < m, without overflow
    function automatic t_word add_mod(input t_word x, input t_word y, input t_word m);
        t_word gap;
        gap = m - y;
        return (x >= gap) ? (x - gap) : (x + y);
    endfunction

    // Double the accumulator, then add x when the current bit is set
    always_comb begin
        n_acc = add_mod(r_acc, r_acc, i_mod);
        if (r_y[WORD_BITS-1]) begin
            n_acc = add_mod(n_acc, r_x, i_mod);
        end
    end

    // Sequence the bit steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(WORD_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold operands and accumulate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WORD_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// ===== rtl/msr_datapath.sv =====
// ----------------------------------------------------------------------------
// msr_datapath
// Working registers of the Tonelli-Shanks search and the shared modular
// multiplier, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module msr_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msr_pkg::t_dp_op    i_op,
    input  msr_pkg::t_in_item  i_in,
    output msr_pkg::t_dp_sts   o_sts,
    output msr_pkg::t_out_item o_res
);
    import msr_pkg::*;

    localparam int KW = CNT_BITS + 1;

    t_word r_a, r_p, r_q, r_z, r_c, r_t, r_r, r_b;
    t_word r_base, r_e, r_acc;
    t_cnt  r_s, r_m, r_ord, r_k;
    t_word r_root;
    logic  r_status;

    logic  mm_start;
    t_word mm_x, mm_y, mm_res;
    logic  mm_done;
    t_word half;

    assign half = r_p >> 1;

    // Select multiplier operands
    always_comb begin
        mm_start = 1'b1;
        mm_x     = r_b;
        mm_y     = r_b;
        unique case (i_op)
            DP_MUL_RED: begin
                mm_x = t_word'(1);
                mm_y = r_a;
            end
            DP_MUL_ACC: begin
                mm_x = r_acc;
                mm_y = r_base;
            end
            DP_MUL_BASE: begin
                mm_x = r_base;
                mm_y = r_base;
            end
            DP_MUL_BB: begin
                mm_x = r_b;
                mm_y = r_b;
            end
            DP_MUL_RB: begin
                mm_x = r_r;
                mm_y = r_b;
            end
            DP_MUL_TC: begin
                mm_x = r_t;
                mm_y = r_c;
            end
            DP_MUL_RR: begin
                mm_x = r_r;
                mm_y = r_r;
            end
            default: mm_start = 1'b0;
        endcase
    end

    msr_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .i_mod   (r_p),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    // Apply commands to the working registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            DP_LOAD: begin
                r_a <= i_in.value;
                r_p <= i_in.prime;
            end
            DP_SET_A: r_a <= mm_res;
            DP_POW_EULER: begin
                r_base <= r_a;
                r_e    <= half;
                r_acc  <= t_word'(1);
            end
            DP_POW_NQR: begin
                r_base <= r_z;
                r_e    <= half;
                r_acc  <= t_word'(1);
            end
            DP_POW_C: begin
                r_base <= r_z;
                r_e    <= r_q;
                r_acc  <= t_word'(1);
            end
            DP_POW_T: begin
                r_base <= r_a;
                r_e    <= r_q;
                r_acc  <= t_word'(1);
            end
            DP_POW_R: begin
                // q is odd, so (q + 1) / 2 is q / 2 + 1
                r_base <= r_a;
                r_e    <= (r_q >> 1) + t_word'(1);
                r_acc  <= t_word'(1);
            end
            DP_SET_ACC: r_acc <= mm_res;
            DP_SET_BASE: begin
                r_base <= mm_res;
                r_e    <= r_e >> 1;
            end
            DP_Q_INIT: begin
                r_q <= r_p - t_word'(1);
                r_s <= '0;
            end
            DP_Q_SHIFT: begin
                r_q <= r_q >> 1;
                r_s <= r_s + 1'b1;
            end
            DP_Z_INIT: r_z <= t_word'(2);
            DP_Z_INC:  r_z <= r_z + t_word'(1);
            DP_SET_C:  r_c <= r_acc;
            DP_SET_T:  r_t <= r_acc;
            DP_SET_R: begin
                r_r <= r_acc;
                r_m <= r_s;
            end
            DP_TT_INIT: begin
                r_b   <= r_t;
                r_ord <= '0;
            end
            DP_TT_STEP: begin
                r_b   <= mm_res;
                r_ord <= r_ord + 1'b1;
            end
            DP_B_INIT: begin
                r_b <= r_c;
                r_k <= '0;
            end
            DP_B_STEP: begin
                r_b <= mm_res;
                r_k <= r_k + 1'b1;
            end
            DP_SET_CSQ: r_c <= mm_res;
            DP_SET_RB:  r_r <= mm_res;
            DP_SET_TC: begin
                r_t <= mm_res;
                r_m <= r_ord;
            end
            DP_RES_ZERO: begin
                r_root   <= '0;
                r_status <= 1'b0;
            end
            DP_RES_FAIL: begin
                r_root   <= '0;
                r_status <= 1'b1;
            end
            DP_RES_LSB: begin
                r_root   <= t_word'(r_a[0]);
                r_status <= 1'b0;
            end
            DP_RES_ROOT: begin
                r_root   <= r_r;
                r_status <= 1'b0;
            end
            default: ;
        endcase
    end

    // Report flags
    always_comb begin
        o_sts.p_zero   = (r_p == '0);
        o_sts.p_one    = (r_p == t_word'(1));
        o_sts.p_two    = (r_p == t_word'(2));
        o_sts.p_even   = ~r_p[0];
        o_sts.a_zero   = (r_a == '0);
        o_sts.e_zero   = (r_e == '0);
        o_sts.e_odd    = r_e[0];
        o_sts.acc_one  = (r_acc == t_word'(1));
        o_sts.acc_pm1  = (r_acc == (r_p - t_word'(1)));
        o_sts.q_even   = ~r_q[0];
        o_sts.z_ok     = (r_z < r_p) && (64'(r_z) <= 64'(NQR_LIMIT));
        o_sts.t_one    = (r_t == t_word'(1));
        o_sts.tt_one   = (r_b == t_word'(1));
        o_sts.ord_lt_m = (r_ord < r_m);
        o_sts.k_loop   = ((KW'(r_k) + KW'(1)) < (KW'(r_m) - KW'(r_ord)));
        o_sts.sq_match = (mm_res == r_a);
        o_sts.mm_done  = mm_done;
    end

    assign o_res.root   = r_root;
    assign o_res.status = r_status;

endmodule

// ===== rtl/msr_ctrl.sv =====
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer for the modular square root: special cases, Euler test,
// non-residue search, exponentiations and the order-correction loop.
// ----------------------------------------------------------------------------
module msr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  msr_pkg::t_dp_sts i_sts,
    output msr_pkg::t_dp_op  o_op
);
    import msr_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // State and return registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        o_op        = DP_NOP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = DP_LOAD;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.p_zero) begin
                    o_op    = DP_RES_FAIL;
                    n_state = S_OUT;
                end else if (i_sts.p_one) begin
                    o_op    = DP_RES_ZERO;
                    n_state = S_OUT;
                end else if (i_sts.p_two) begin
                    o_op    = DP_RES_LSB;
                    n_state = S_OUT;
                end else begin
                    o_op    = DP_MUL_RED;
                    n_state = S_RED_W;
                end
            end
            S_RED_W: begin
                if (i_sts.mm_done) begin
                    o_op    = DP_SET_A;
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_sts.a_zero) begin
                    o_op    = DP_RES_ZERO;
                    n_state = S_OUT;
                end else if (i_sts.p_even) begin
                    o_op    = DP_RES_FAIL;
                    n_state = S_OUT;
                end else begin
                    o_op    = DP_POW_EULER;
                    n_ret   = S_EULER_D;
                    n_state = S_POW;
                end
            end
            // Square-and-multiply, returning to r_ret
            S_POW: begin
                if (i_sts.e_zero) begin
                    n_state = r_ret;
                end else if (i_sts.e_odd) begin
                    o_op    = DP_MUL_ACC;
                    n_state = S_POW_WA;
                end else begin
                    o_op    = DP_MUL_BASE;
                    n_state = S_POW_WB;
                end
            end
            S_POW_WA: begin
                if (i_sts.mm_done) begin
                    o_op    = DP_SET_ACC;
                    n_state = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                o_op    = DP_MUL_BASE;
                n_state = S_POW_WB;
            end
            S_POW_WB: begin
                if (i_sts.mm_done) begin
                    o_op    = DP_SET_BASE;
                    n_state = S_POW;
                end
            end
            S_EULER_D: begin
                if (i_sts.acc_one) begin
                    o_op    = DP_Q_INIT;
                    n_state = S_Q_LOOP;
                end else begin
                    o_op    = DP_RES_FAIL;
                    n_state = S_OUT;
                end
            end
            S_Q_LOOP: begin
                if (i_sts.q_even) begin
                    o_op = DP_Q_SHIFT;
                end else begin
                    o_op    = DP_Z_INIT;
                    n_state = S_NQR;
                end
            end
            S_NQR: begin
                if (i_sts.z_ok) begin
                    o_op    = DP_POW_NQR;
                    n_ret   = S_NQR_D;
                    n_state = S_POW;
                end else begin
                    o_op    = DP_RES_FAIL;
                    n_state = S_OUT;
                end
            end
            S_NQR_D: begin
                if (i_sts.acc_pm1) begin
                    o_op    = DP_POW_C;
                    n_ret   = S_C_D;
                    n_state = S_POW;
                end else begin
                    o_op    = DP_Z_INC;
                    n_state = S_NQR;
                end
            end
            S_C_D: begin
                o_op    = DP_SET_C;
                n_state = S_T_START;
            end
            S_T_START: begin
                o_op    = DP_POW_T;
                n_ret   = S_T_D;
                n_state = S_POW;
            end
            S_T_D: begin
                o_op    = DP_SET_T;
                n_state = S_R_START;
            end
            S_R_START: begin
                o_op    = DP_POW_R;
                n_ret   = S_R_D;
                n_state = S_POW;
            end
            S_R_D: begin
                o_op    = DP_SET_R;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (i_sts.t_one) begin
                    o_op    = DP_MUL_RR;
                    n_state = S_FIN_W;
                end else begin
                    o_op    = DP_TT_INIT;
                    n_state = S_ORD;
                end
            end
            // Find the order of t by repeated squaring
            S_ORD: begin
                if (i_sts.tt_one && i_sts.ord_lt_m) begin
                    o_op    = DP_B_INIT;
                    n_state = S_BLOOP;
                end else if (i_sts.ord_lt_m) begin
                    o_op    = DP_MUL_BB;
                    n_state = S_ORD_W;
                end else begin
                    o_op    = DP_RES_FAIL;
                    n_state = S_OUT;
                end
            end
            S_ORD_W: begin
                if (i_sts.mm_done) begin
                    o_op    = DP_TT_STEP;
                    n_state = S_ORD;
                end
            end
            S_BLOOP: begin
                o_op = DP_MUL_BB;
                if (i_sts.k_loop) begin
                    n_state = S_B_W;
                end else begin
                    n_state = S_CSQ_W;
                end
            end
            S_B_W: begin
                if (i_sts.mm_done) begin
                    o_op    = DP_B_STEP;
                    n_state = S_BLOOP;
                end
            end
            S_CSQ_W: begin
                if (i_sts.mm_done) begin
                    o_op    = DP_SET_CSQ;
                    n_state = S_RB;
                end
            end
            S_RB: begin
                o_op    = DP_MUL_RB;
                n_state = S_RB_W;
            end
            S_RB_W: begin
                if (i_sts.mm_done) begin
                    o_op    = DP_SET_RB;
                    n_state = S_TC;
                end
            end
            S_TC: begin
                o_op    = DP_MUL_TC;
                n_state = S_TC_W;
            end
            S_TC_W: begin
                if (i_sts.mm_done) begin
                    o_op    = DP_SET_TC;
                    n_state = S_LOOP;
                end
            end
            S_FIN_W: begin
                if (i_sts.mm_done) begin
                    o_op    = i_sts.sq_match ? DP_RES_ROOT : DP_RES_FAIL;
                    n_state = S_OUT;
                end
            end
            // Hold the result until the transaction completes
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/modular_square_root_top.sv =====
// Special moduli: the controller takes the input in S_IDLE, sets the result in S_CHK and
// presents it in S_OUT. Otherwise the time depends on the data: every modular product runs
// on the one shared bit-serial multiplier.
// Transactions: one at a time; the next is taken once the result leaves.
// Reset: synchronous, active low; returns the controller to idle, no result pending.
// ----------------------------------------------------------------------------
// modular_square_root_top
// Tonelli-Shanks modular square root with a controller and a shared
// modular-multiply datapath.
// ----------------------------------------------------------------------------
module modular_square_root_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  msr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output msr_pkg::t_out_item o_out_data
);
    import msr_pkg::*;

    t_dp_op  dp_op;
    t_dp_sts dp_sts;

    msr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_op        (dp_op)
    );

    msr_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (dp_op),
        .i_in    (i_in_data),
        .o_sts   (dp_sts),
        .o_res   (o_out_data)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives value/prime transactions into modular_square_root_top and checks
// every root and status against a typed table entry or a Tonelli-Shanks predictor
// in the bench. A directed table covers the special moduli and edge values.
// Random items follow: mostly prime moduli with random residues and non-residues,
// plus small odd, tiny and even moduli; idle gaps on both sides, a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
    import msr_pkg::*;

    localparam int  RAND_ITEMS = 150;
    localparam int  IDLE_LIMIT = 500000;
    localparam int  STALL_LEN  = 3000;
    localparam int  N_ROWS     = 18;

    typedef longint unsigned u64;

    typedef struct {
        t_word value;
        t_word prime;
        bit    typed;
        t_word root;
        logic  status;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_data;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_data;

    t_out_item  root_q[$];
    int         n_err;
    int         n_sent;
    int         n_got;
    int         n_nonres;
    int         idle_cnt;
    bit         stall_req;
    t_row       rows[N_ROWS];

    modular_square_root_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic u64 mulm(u64 x, u64 y, u64 m);
        return (x * y) % m;
    endfunction

    function automatic u64 powm(u64 b, u64 e, u64 m);
        u64 acc;
        acc = 1;
        while (e != 0) begin
            if (e[0]) acc = mulm(acc, b, m);
            b = mulm(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Tonelli-Shanks core; a in 1..p-1, p odd, Euler test passed
    function automatic bit shanks_root(u64 a, u64 p, output u64 r);
        u64 q, z, c, t, tt, b, cand;
        int s, m, ord;
        bit found;
        q = p - 1; s = 0; found = 0; z = 0; r = 0;
        while (!q[0]) begin
            q = q >> 1;
            s++;
        end
        for (cand = 2; cand < p && cand <= NQR_LIMIT; cand++) begin
            if (powm(cand, (p - 1) >> 1, p) == p - 1) begin
                z = cand;
                found = 1;
                break;
            end
        end
        if (!found) return 0;
        c = powm(z, q, p);
        t = powm(a, q, p);
        r = powm(a, (q + 1) >> 1, p);
        m = s;
        while (t != 1) begin
            tt = t;
            ord = 0;
            while (tt != 1 && ord < m) begin
                tt = mulm(tt, tt, p);
                ord++;
            end
            if (tt != 1 || ord >= m) return 0;
            b = c;
            for (int k = 0; k + 1 < m - ord; k++) b = mulm(b, b, p);
            c = mulm(b, b, p);
            r = mulm(r, b, p);
            t = mulm(t, c, p);
            m = ord;
        end
        return mulm(r, r, p) == a;
    endfunction

    function automatic t_out_item predict_root(t_word value, t_word prime);
        t_out_item res;
        u64 a, p, r;
        a = value; p = prime; r = 0;
        res.root = '0; res.status = 1'b0;
        if (p == 0) begin
            res.status = 1'b1;
        end else if (p == 2) begin
            res.root = t_word'(a & 1);
        end else if (p != 1) begin
            a = a % p;
            if (a == 0) begin
                res.root = '0;
            end else if (!p[0]) begin
                res.status = 1'b1;
            end else if (powm(a, (p - 1) >> 1, p) != 1) begin
                res.status = 1'b1;
            end else if (!shanks_root(a, p, r)) begin
                res.status = 1'b1;
            end else begin
                res.root = t_word'(r);
            end
        end
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic bit is_prime(u64 n);
        u64 d, x;
        int s;
        int bases[5] = '{2, 3, 5, 7, 11};
        bit comp;
        if (n < 2) return 0;
        foreach (bases[i]) begin
            if (n == bases[i]) return 1;
            if (n % bases[i] == 0) return 0;
        end
        d = n - 1; s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        foreach (bases[i]) begin
            x = powm(bases[i], d, n);
            if (x == 1 || x == n - 1) continue;
            comp = 1;
            for (int j = 1; j < s; j++) begin
                x = mulm(x, x, n);
                if (x == n - 1) begin
                    comp = 0;
                    break;
                end
            end
            if (comp) return 0;
        end
        return 1;
    endfunction

    // odd prime of the given width, with 2^twos (or a lower power, once relaxed) dividing p-1
    function automatic t_word rand_prime(int bits, int twos);
        u64 p;
        int tries;
        tries = 0;
        do begin
            // relax the power of two when the pattern leaves too few candidates
            if (tries >= 64 && twos > 1) begin
                twos--;
                tries = 0;
            end
            p = u64'($urandom) & ((u64'(1) << bits) - 1);
            p = ((p >> twos) << twos) | 1;
            p = p | (u64'(1) << (bits - 1));
            tries++;
        end while (p < 3 || !is_prime(p));
        return t_word'(p);
    endfunction

    // residue lifted by a random multiple of p where it fits
    function automatic t_word rand_square(t_word prime);
        u64 x, v, k;
        x = u64'($urandom) % prime;
        v = mulm(x, x, prime);
        k = (64'hFFFF_FFFF - v) / prime;
        v = v + prime * (u64'($urandom) % (k + 1));
        return t_word'(v);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    // offer one transaction and hold it until accepted
    task automatic send_item(t_word value, t_word prime, bit typed, t_out_item want);
        int gap;
        in_valid <= 1'b1;
        in_data  <= '{value: value, prime: prime};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        root_q.push_back(typed ? want : predict_root(value, prime));
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_wait();
        while (root_q.size() != 0) @(posedge i_clk);
    endtask

    // ---------------- receiver ----------------
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (stall_req) begin
                // long hold-off so the block backs up into its input
                out_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge i_clk);
                stall_req = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            n_got++;
            if (out_data.status) n_nonres++;
            if (root_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected result root=%h status=%b",
                             out_data.root, out_data.status);
            end else begin
                want = root_q.pop_front();
                if (out_data.root !== want.root || out_data.status !== want.status) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: result %0d exp root=%h status=%b got root=%h status=%b",
                                 n_got, want.root, want.status, out_data.root, out_data.status);
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("modular_square_root_top test failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        t_word p, v;
        int r, bits;
        n_err = 0; n_sent = 0; n_got = 0; n_nonres = 0; idle_cnt = 0;
        stall_req = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        i_rst_n  = 1'b0;

        // directed table: typed results for the first twelve rows, predictor for the rest
        rows = '{
            '{32'h0000_0005, 32'h0000_0000, 1, 32'h0, 1'b1},  // zero modulus
            '{32'hFFFF_FFFF, 32'h0000_0001, 1, 32'h0, 1'b0},  // modulus one
            '{32'hFFFF_FFFF, 32'h0000_0002, 1, 32'h1, 1'b0},  // modulus two, odd value
            '{32'hFFFF_FFFE, 32'h0000_0002, 1, 32'h0, 1'b0},  // modulus two, even value
            '{32'h0000_0000, 32'h0000_0007, 1, 32'h0, 1'b0},  // zero value
            '{32'h0000_0015, 32'h0000_0007, 1, 32'h0, 1'b0},  // multiple of p
            '{32'h0000_0003, 32'h0000_0004, 1, 32'h0, 1'b1},  // even modulus
            '{32'h0000_0005, 32'hFFFF_FFFE, 1, 32'h0, 1'b1},  // even modulus, top
            '{32'h0000_0003, 32'h0000_0007, 1, 32'h0, 1'b1},  // Euler test fails
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 1'b0},  // all ones, zero residue
            '{32'h0000_0001, 32'h0000_0009, 1, 32'h0, 1'b1},  // no non-residue found
            '{32'h0000_0004, 32'h0000_000F, 1, 32'h0, 1'b1},  // composite, Euler fails
            '{32'h0000_0002, 32'h0000_0007, 0, 32'h0, 1'b0},
            '{32'h0000_000A, 32'h0000_000D, 0, 32'h0, 1'b0},
            '{32'h0000_0002, 32'h0000_0011, 0, 32'h0, 1'b0},
            '{32'h0000_0004, 32'hFFFF_FFFB, 0, 32'h0, 1'b0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFB, 0, 32'h0, 1'b0},
            '{32'h0000_0001, 32'h0000_0019, 0, 32'h0, 1'b0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_item(rows[i].value, rows[i].prime, rows[i].typed,
                      '{root: rows[i].root, status: rows[i].status});

        // pause the sender until every directed result is back
        in_valid <= 1'b0;
        drain_wait();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 40) stall_req = 1'b1;
            if (n == 100) begin
                in_valid <= 1'b0;
                drain_wait();
                @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                // prime modulus, mostly full width, varied powers of two in p-1
                bits = ($urandom_range(0, 9) < 7) ? 32 : $urandom_range(3, 16);
                p = rand_prime(bits, ($urandom_range(0, 4) == 0) ?
                               $urandom_range(1, bits - 2) : $urandom_range(1, 3));
                v = ($urandom_range(0, 1) != 0) ? rand_square(p) : t_word'($urandom);
            end else if (r < 90) begin
                p = t_word'($urandom_range(1, 49) * 2 + 1);
                v = t_word'($urandom);
            end else if (r < 95) begin
                p = t_word'($urandom_range(0, 2));
                v = t_word'($urandom);
            end else begin
                p = t_word'($urandom) & ~t_word'(1);
                v = t_word'($urandom);
            end
            send_item(v, p, 0, '0);
        end
        in_valid <= 1'b0;

        drain_wait();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d transactions: special moduli, small composites and random primes",
                 n_sent);
        $display("Results received: %0d, flagged non-residues: %0d, mismatches: %0d",
                 n_got, n_nonres, n_err);
        if (n_err == 0 && root_q.size() == 0) begin
            $display("modular_square_root_top test passed");
        end else begin
            $display("modular_square_root_top test failed");
        end
        $finish;
    end

endmodule
